### rtl/tkst_pkg.sv
// Shared types and constants of the top-k score tracker.
package tkst_pkg;

  localparam int unsigned MaxEntriesDef = 1024;
  localparam int unsigned CfgW          = 11;
  localparam int unsigned SlotW         = 10;
  localparam logic [CfgW-1:0] EntriesWantedRst = 11'd1024;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [31:0]      doc_id;
    logic [31:0]      score;
    logic [SlotW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic        entered;
    logic [31:0] min_score;
    logic [31:0] read_doc_id;
    logic [31:0] read_score;
  } res_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] sc;
  } entry_t;

  // queued command, op decoded and read range checked
  typedef struct packed {
    op_e              op;
    logic [31:0]      doc_id;
    logic [31:0]      score;
    logic [SlotW-1:0] slot;
    logic             read_ok;
  } job_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD0,
    S_RDMIN,
    S_SCAN,
    S_DUP,
    S_CLR,
    S_READ
  } state_e;

  function automatic logic ranks_below(entry_t a, entry_t b);
    return (a.sc < b.sc) || ((a.sc == b.sc) && (a.id < b.id));
  endfunction

endpackage

### rtl/tkst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkst_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/tkst_front.sv
// Front end: takes command beats, decodes them and queues them for the back end.
module tkst_front import tkst_pkg::*; #(
  parameter int unsigned MaxEntries = MaxEntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic job_valid_o,
  output job_t job_o,
  input  logic job_pop_i
);

  job_t       fifo_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  job_t       job_new;

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rptr_q];

  always_comb begin
    job_new.op      = op_e'(cmd_i.op);
    job_new.doc_id  = cmd_i.doc_id;
    job_new.score   = cmd_i.score;
    job_new.slot    = cmd_i.slot;
    job_new.read_ok = (32'(cmd_i.slot) < 32'(MaxEntries));
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ (job_pop_i && job_valid_o);
    cnt_d  = cnt_q + 2'(push) - 2'(job_pop_i && job_valid_o);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= job_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### rtl/tkst_back.sv
// Back end: table update, minimum and duplicate scan, clear and read.
module tkst_back import tkst_pkg::*; #(
  parameter int unsigned MaxEntries = MaxEntriesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] entries_wanted_i,
  input  logic            job_valid_i,
  input  job_t            job_i,
  output logic            job_pop_o,
  output logic            done_o,
  output res_t            res_o
);

  localparam int unsigned AW   = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CW   = $clog2(MaxEntries + 1);
  localparam int unsigned CMPW = (CW > CfgW) ? CW : CfgW;
  localparam logic [CMPW-1:0] MaxC = CMPW'(MaxEntries);

  state_e           state_q, state_d;
  job_t             job_q, job_d;
  logic [SlotW-1:0] min_slot_q, min_slot_d;
  logic [31:0]      lowest_q, lowest_d;
  entry_t           old_q, old_d, best_q, best_d;
  logic [AW-1:0]    newmin_q, newmin_d, dup_q, dup_d;
  logic             have_dup_q, have_dup_d;
  logic [CW-1:0]    iss_q, iss_d, pidx_q, pidx_d;
  logic             pv_q, pv_d;
  logic             done_d;
  res_t             res_d;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  entry_t           wdata, rdata;
  logic [CMPW-1:0]  n;
  logic [SlotW-1:0] ms;
  entry_t           new_e, fin_best;
  logic [AW-1:0]    fin_min;

  tkst_ram #(.Width($bits(entry_t)), .Depth(MaxEntries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign n = (CMPW'(entries_wanted_i) > MaxC) ? MaxC : CMPW'(entries_wanted_i);

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    min_slot_d = min_slot_q;
    lowest_d   = lowest_q;
    old_d      = old_q;
    best_d     = best_q;
    newmin_d   = newmin_q;
    dup_d      = dup_q;
    have_dup_d = have_dup_q;
    iss_d      = iss_q;
    pidx_d     = pidx_q;
    pv_d       = 1'b0;
    job_pop_o  = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = '0;
    done_d     = 1'b0;
    res_d      = '0;
    new_e.id   = job_q.doc_id;
    new_e.sc   = job_q.score;
    ms         = '0;
    fin_best   = best_q;
    fin_min    = newmin_q;

    case (state_q)
      S_INIT, S_CLR: begin
        we    = 1'b1;
        waddr = iss_q[AW-1:0];
        iss_d = iss_q + 1'b1;
        if (CMPW'(iss_q) == MaxC - 1'b1) begin
          iss_d      = '0;
          min_slot_d = '0;
          lowest_d   = '0;
          state_d    = S_IDLE;
          done_d     = (state_q == S_CLR);
        end
      end
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          iss_d     = '0;
          case (job_i.op)
            OP_OFFER: begin
              if (n == '0) begin
                done_d = 1'b1;
              end else begin
                raddr   = '0;
                state_d = S_RD0;
              end
            end
            OP_CLEAR: state_d = S_CLR;
            OP_READ: begin
              if (job_i.read_ok) begin
                raddr   = AW'(job_i.slot);
                state_d = S_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_RD0: begin
        ms = ((lowest_q == '0) && (rdata.id == '0)) ? '0 : min_slot_q;
        if (CMPW'(ms) >= n) begin
          ms = '0;
        end
        min_slot_d = ms;
        raddr      = AW'(ms);
        state_d    = S_RDMIN;
      end
      S_RDMIN: begin
        old_d = rdata;
        if (!ranks_below(rdata, new_e)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          we         = 1'b1;
          waddr      = AW'(min_slot_q);
          wdata      = new_e;
          have_dup_d = 1'b0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (CMPW'(iss_q) < n) begin
          raddr  = iss_q[AW-1:0];
          iss_d  = iss_q + 1'b1;
          pv_d   = 1'b1;
          pidx_d = iss_q;
        end
        if (pv_q) begin
          if ((rdata.id == job_q.doc_id) && (pidx_q[AW-1:0] != AW'(min_slot_q))) begin
            dup_d      = pidx_q[AW-1:0];
            have_dup_d = 1'b1;
          end
          if (pidx_q == '0) begin
            best_d   = rdata;
            newmin_d = '0;
          end else if (ranks_below(rdata, best_q)) begin
            best_d   = rdata;
            newmin_d = pidx_q[AW-1:0];
          end
          if (CMPW'(pidx_q) == n - 1'b1) begin
            state_d = S_DUP;
          end
        end
      end
      S_DUP: begin
        if (have_dup_q) begin
          we    = 1'b1;
          waddr = dup_q;
          wdata = old_q;
          // the minimum slot may be the one that now takes back the old entry
          if ((newmin_q == dup_q) || ranks_below(old_q, best_q)) begin
            fin_best = old_q;
            fin_min  = dup_q;
          end
        end
        lowest_d   = fin_best.sc;
        min_slot_d = SlotW'(fin_min);
        done_d     = 1'b1;
        res_d.entered = 1'b1;
        state_d    = S_IDLE;
      end
      S_READ: begin
        res_d.read_doc_id = rdata.id;
        res_d.read_score  = rdata.sc;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    res_d.min_score = lowest_d;
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    old_q    <= old_d;
    best_q   <= best_d;
    newmin_q <= newmin_d;
    dup_q    <= dup_d;
    pidx_q   <= pidx_d;
    res_o    <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      min_slot_q <= '0;
      lowest_q   <= '0;
      have_dup_q <= 1'b0;
      iss_q      <= '0;
      pv_q       <= 1'b0;
      done_o     <= 1'b0;
    end else begin
      state_q    <= state_d;
      min_slot_q <= min_slot_d;
      lowest_q   <= lowest_d;
      have_dup_q <= have_dup_d;
      iss_q      <= iss_d;
      pv_q       <= pv_d;
      done_o     <= done_d;
    end
  end

endmodule

### rtl/top_k_score_tracker.sv
// Top level of the top-k score tracker.
// Offer: replaces the minimum if outranked, then scans the n slots in use on one read port.
// Clear rewrites all slots; a read reads one slot; other ops and n = 0 offers end in idle.
// One op at a time in the back end; a two-beat queue keeps start taken until busy_o (full).
// Reset: table cleared by a pass over all MaxEntries slots, commands queue meanwhile.
// Results strobe on done_o for one cycle; the receiver cannot stall.
module top_k_score_tracker import tkst_pkg::*; #(
  parameter int unsigned MaxEntries = MaxEntriesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cmd_t            cmd_i,
  output logic            busy_o,
  output logic            done_o,
  output res_t            res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [CfgW-1:0] entries_wanted_q;
  logic            job_valid, job_pop;
  job_t            job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_wanted_q <= EntriesWantedRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entries_wanted_q <= cfg_data_i;
    end
  end

  tkst_front #(.MaxEntries(MaxEntries)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .busy_o     (busy_o),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_pop_i  (job_pop)
  );

  tkst_back #(.MaxEntries(MaxEntries)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entries_wanted_i(entries_wanted_q),
    .job_valid_i     (job_valid),
    .job_i           (job),
    .job_pop_o       (job_pop),
    .done_o          (done_o),
    .res_o           (res_o)
  );

endmodule

### rtl/tkst_checker.sv
// Port-level checker of the top-k score tracker and its bind.
module tkst_checker import tkst_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input res_t res_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.entered |-> res_o.read_doc_id == '0 && res_o.read_score == '0)
    else $error("entered beat carries read data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.entered |-> !$past(done_o))
    else $error("offer finished too fast");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !done_o && !busy_o)
    else $error("activity right after reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy without an accepted beat");

endmodule

bind top_k_score_tracker tkst_checker u_tkst_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .done_o (done_o),
  .res_o  (res_o)
);
